[rtl/core/fbdc_pkg.sv]
// ----------------------------------------------------------------------------
// fbdc_pkg
// Constants and types for the fractional baud divisor calculator.
// ----------------------------------------------------------------------------
package fbdc_pkg;

  localparam longint unsigned CLOCK_HZ = 64'd32000000;

  localparam int BAUD_W  = 24;
  localparam int DIV_W   = 32;
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int SCALE_W = 3;

  localparam logic [DIV_W-1:0]   DIVIDEND   = DIV_W'(CLOCK_HZ * 64);
  localparam logic [BAUD_W-1:0]  BAUD_MAX   = BAUD_W'(CLOCK_HZ / 16);
  localparam logic [DIV_W-1:0]   Q_OFFSET   = DIV_W'(1024);
  localparam logic [DIV_W-1:0]   NORM_LIMIT = DIV_W'(2096640);
  localparam logic [SCALE_W-1:0] MAX_SCALE  = SCALE_W'(7);
  localparam logic [CNT_W-1:0]   DIV_LAST   = CNT_W'(DIV_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUB,
    ST_NORM,
    ST_FIN
  } state_t;

endpackage

[rtl/core/fractional_baud_divisor_calc_unit.sv]
// ----------------------------------------------------------------------------
// fractional_baud_divisor_calc_unit
// Turns a requested baud rate into the two baud-control bytes of a
// fractional baud generator.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | baud                           | start & !busy
//  result  | ok, baud_low, baud_high        | done, one cycle, no back-pressure
//
//  A valid rate takes a restoring divide of 32 quotient bits (one quotient
//  bit per cycle through one 25-bit subtractor), one offset step, up to 7
//  shift steps, one step that ends the shifts and one finish step, after
//  which done pulses with the result.
//  A rejected rate (zero or above CLOCK_HZ/16) gives done in the next cycle.
//  busy is high while an item is in work. Synchronous reset clears control.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_calc_unit
  import fbdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [BAUD_W-1:0] baud,
  output logic              busy,
  output logic              done,
  output logic              ok,
  output logic [7:0]        baud_low,
  output logic [7:0]        baud_high
);

  state_t state, state_next;

  logic [DIV_W-1:0]   q, q_next;
  logic [BAUD_W-1:0]  rem, rem_next;
  logic [BAUD_W-1:0]  divisor, divisor_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [SCALE_W-1:0] scale, scale_next;
  logic               done_next, ok_next;
  logic [7:0]         baud_low_next, baud_high_next;

  logic               reject;
  logic               can_shift;
  logic [BAUD_W:0]    trial;
  logic [BAUD_W:0]    diff;
  logic [15:0]        sel;
  logic [3:0]         nib;

  assign reject    = (baud == '0) || (baud > BAUD_MAX);
  assign can_shift = (q < NORM_LIMIT) && (scale < MAX_SCALE);
  assign trial     = {rem, q[DIV_W-1]};
  assign diff      = trial - {1'b0, divisor};
  assign sel       = q[25:10];
  assign nib       = 4'(5'd16 - {2'b00, scale});
  assign busy      = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !reject) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (count == DIV_LAST) state_next = ST_SUB;
      end
      ST_SUB:  state_next = ST_NORM;
      ST_NORM: begin
        if (!can_shift) state_next = ST_FIN;
      end
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_next         = q;
    rem_next       = rem;
    divisor_next   = divisor;
    count_next     = count;
    scale_next     = scale;
    done_next      = 1'b0;
    ok_next        = ok;
    baud_low_next  = baud_low;
    baud_high_next = baud_high;
    unique case (state)
      ST_IDLE: begin
        q_next       = DIVIDEND;
        rem_next     = '0;
        divisor_next = baud;
        count_next   = '0;
        scale_next   = '0;
        if (start && reject) begin
          done_next      = 1'b1;
          ok_next        = 1'b0;
          baud_low_next  = '0;
          baud_high_next = '0;
        end
      end
      ST_DIV: begin
        // restoring step: one quotient bit per cycle
        if (diff[BAUD_W]) begin
          rem_next = trial[BAUD_W-1:0];
          q_next   = {q[DIV_W-2:0], 1'b0};
        end else begin
          rem_next = diff[BAUD_W-1:0];
          q_next   = {q[DIV_W-2:0], 1'b1};
        end
        count_next = count + CNT_W'(1);
      end
      ST_SUB: q_next = q - Q_OFFSET;
      ST_NORM: begin
        if (can_shift) begin
          q_next     = {q[DIV_W-2:0], 1'b0};
          scale_next = scale + SCALE_W'(1);
        end
      end
      ST_FIN: begin
        done_next      = 1'b1;
        ok_next        = 1'b1;
        baud_low_next  = sel[7:0];
        baud_high_next = {nib, 4'b0000} | sel[15:8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    q         <= q_next;
    rem       <= rem_next;
    divisor   <= divisor_next;
    count     <= count_next;
    scale     <= scale_next;
    ok        <= ok_next;
    baud_low  <= baud_low_next;
    baud_high <= baud_high_next;
  end

endmodule
